// ===== rtl/isr_pkg.sv =====
package isr_pkg;

	localparam int Channels = 4;
	localparam int LevelW = 7;
	localparam int ErrW = 14;

	localparam logic [31:0] MaxWordReset = 32'hFAAF_C8FA;
	localparam logic [31:0] MinWordReset = 32'h0101_0101;
	localparam logic [7:0] EnterSumReset = 8'd150;
	localparam logic [15:0] EntryDistReset = 16'd1000;
	localparam logic [15:0] RingDistReset = 16'd350;
	localparam logic [8:0] ExitSumReset = 9'd300;
	localparam logic [15:0] SettleReset = 16'd500;

	localparam logic [2:0] RegMaxWord = 3'd0;
	localparam logic [2:0] RegMinWord = 3'd1;
	localparam logic [2:0] RegEnterSum = 3'd2;
	localparam logic [2:0] RegEntryDist = 3'd3;
	localparam logic [2:0] RegRingDist = 3'd4;
	localparam logic [2:0] RegExitSum = 3'd5;
	localparam logic [2:0] RegSettle = 3'd6;

	localparam logic [6:0] LevelMax = 7'd100;
	localparam logic [6:0] SlantEnterMin = 7'd20;
	localparam logic [15:0] SettleStep = 16'd5;
	localparam logic [13:0] ExitError = 14'd3840;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LVL_LOAD,
		ST_LVL_DIV,
		ST_LVL_STORE,
		ST_MODE,
		ST_SQ_LOAD,
		ST_SQ_RUN,
		ST_SQ_STORE,
		ST_ERR_LOAD,
		ST_ERR_DIV,
		ST_DONE
	} isr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       in_load;
		logic       lvl_load;
		logic       div_step;
		logic       lvl_store;
		logic       mode_update;
		logic       sq_load;
		logic       sq_step;
		logic       sq_store;
		logic       err_load;
		logic       out_load;
		logic [1:0] idx;
	} isr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic sq_done;
		logic fixed_err;
	} isr_stat_t;

endpackage

// ===== rtl/isr_datapath.sv =====
module isr_datapath
	import isr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  isr_cmd_t          cmd,
	output isr_stat_t         stat,
	input  logic [7:0]        left_raw,
	input  logic [7:0]        left_slant_raw,
	input  logic [7:0]        right_slant_raw,
	input  logic [7:0]        right_raw,
	input  logic signed [15:0] wheel_speed,
	input  logic [31:0]       max_word,
	input  logic [31:0]       min_word,
	input  logic [7:0]        enter_sum,
	input  logic [15:0]       entry_dist,
	input  logic [15:0]       ring_dist,
	input  logic [8:0]        exit_sum,
	input  logic [15:0]       settle_lim,
	output logic signed [13:0] steer_error,
	output logic [6:0]        left_level,
	output logic [6:0]        left_slant_level,
	output logic [6:0]        right_slant_level,
	output logic [6:0]        right_level,
	output logic              ring_seen,
	output logic              ring_entering,
	output logic              ring_inside,
	output logic              ring_leaving
);

	// Request captured at acceptance.
	logic [7:0]  l_raw_q, ls_raw_q, rs_raw_q, r_raw_q;
	logic signed [15:0] speed_q;

	// Shared restoring divider: 33-bit numerator, 24-bit divisor, one bit per cycle.
	logic [32:0] dnum_q;
	logic [23:0] dden_q;
	logic [24:0] drem_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q;
	logic        dzero_q;
	logic [24:0] drem_sh;
	logic [6:0]  lvl_q [Channels];
	logic [7:0]  raw_sel, mx_sel, mn_sel;
	logic [3:0]  flags_q;
	logic [15:0] appr_q, ent_q, settle_q;

	// Square-root unit: one result bit per cycle.
	logic [35:0] sq_v_q;
	logic [35:0] sq_rem_q;
	logic [17:0] sq_res_q;
	logic [4:0]  sq_cnt_q;
	logic [17:0] lq_q, rq_q;
	logic [9:0]  ri_q;
	logic [37:0] sq_trial;
	logic [37:0] sq_remsh;

	// Operand pairing by mode.
	logic [7:0]  pa, pb, pc, pd;
	logic [16:0] ls_sum, rs_sum;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			l_raw_q <= left_raw;
			ls_raw_q <= left_slant_raw;
			rs_raw_q <= right_slant_raw;
			r_raw_q <= right_raw;
			speed_q <= wheel_speed;
		end
	end

	always_comb begin
		raw_sel = l_raw_q;
		case (cmd.idx)
			2'd0: raw_sel = l_raw_q;
			2'd1: raw_sel = ls_raw_q;
			2'd2: raw_sel = rs_raw_q;
			default: raw_sel = r_raw_q;
		endcase
		mx_sel = max_word[8*cmd.idx +: 8];
		mn_sel = min_word[8*cmd.idx +: 8];
	end

	always_comb begin
		pa = {1'b0, lvl_q[0]};
		pb = {lvl_q[1], 1'b0};
		pc = {1'b0, lvl_q[3]};
		pd = {lvl_q[2], 1'b0};
		if (flags_q[0] && !flags_q[2]) begin
			if (flags_q[1] && !flags_q[3]) begin
				pb = {1'b0, lvl_q[1]};
				pd = {1'b0, lvl_q[2]};
			end else begin
				pa = {lvl_q[0], 1'b0};
				pb = {1'b0, lvl_q[1]};
				pc = {lvl_q[3], 1'b0};
				pd = {1'b0, lvl_q[2]};
			end
		end
		ls_sum = 17'(pa) * 17'(pa) + 17'(pb) * 17'(pb);
		rs_sum = 17'(pc) * 17'(pc) + 17'(pd) * 17'(pd);
	end

	assign drem_sh = {drem_q[23:0], dnum_q[32]};
	assign stat.div_done = (dcnt_q == 6'd0);
	assign stat.sq_done = (sq_cnt_q == 5'd0);
	assign stat.fixed_err = flags_q[2] && flags_q[3];

	// Level, divider, counters and mode flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			flags_q <= '0;
			appr_q <= '0;
			ent_q <= '0;
			settle_q <= '0;
		end else begin
			if (cmd.lvl_load) begin
				// Numerator is (raw-min)*100, placed at the top of the 33-bit word.
				dzero_q <= !(mx_sel > mn_sel) || (raw_sel < mn_sel);
				dnum_q <= {15'(raw_sel - mn_sel) * 15'(LevelMax), 18'd0};
				dden_q <= {16'd0, 8'(mx_sel - mn_sel)};
				drem_q <= '0;
				dneg_q <= 1'b0;
				dcnt_q <= 6'd15;
			end else if (cmd.err_load) begin
				dzero_q <= 1'b0;
				dden_q <= {5'd0, 19'(lq_q) + 19'(rq_q) + 19'd256};
				drem_q <= '0;
				dcnt_q <= 6'd33;
				begin
					logic signed [18:0] diff;
					logic [18:0] mag;
					diff = $signed({1'b0, ri_q, 8'd0}) - $signed({1'b0, lq_q});
					mag = diff[18] ? 19'(-diff) : diff;
					dneg_q <= diff[18];
					dnum_q <= 33'(mag) * 33'd5120;
				end
			end else if (cmd.div_step && dcnt_q != 6'd0) begin
				dcnt_q <= dcnt_q - 6'd1;
				if (drem_sh >= {1'b0, dden_q}) begin
					drem_q <= drem_sh - {1'b0, dden_q};
					dnum_q <= {dnum_q[31:0], 1'b1};
				end else begin
					drem_q <= drem_sh;
					dnum_q <= {dnum_q[31:0], 1'b0};
				end
			end
			if (cmd.mode_update) begin
				logic [3:0]  f;
				logic [15:0] a, e, s;
				logic [16:0] mag;
				logic [16:0] t;
				f = flags_q;
				a = appr_q;
				e = ent_q;
				s = settle_q;
				mag = speed_q[15] ? 17'(-$signed({speed_q[15], speed_q}))
					: 17'(speed_q);
				if (8'(lvl_q[0]) + 8'(lvl_q[3]) > enter_sum) f[0] = 1'b1;
				if (a > entry_dist && f[0] && lvl_q[2] > SlantEnterMin) f[1] = 1'b1;
				if (f[1] && e > ring_dist) f[2] = 1'b1;
				if (f[2] && (9'(lvl_q[0]) + 9'(lvl_q[1]) + 9'(lvl_q[2]) + 9'(lvl_q[3])
					> exit_sum)) begin
					f[3] = 1'b1;
					a = '0;
					e = '0;
				end
				if (s > settle_lim) begin
					f = '0;
					s = '0;
				end
				if (f[0] && !f[1]) begin
					t = 17'(a) + mag;
					a = t[16] ? 16'hFFFF : t[15:0];
				end
				if (f[1] && !f[2]) begin
					t = 17'(e) + mag;
					e = t[16] ? 16'hFFFF : t[15:0];
				end
				if (f[3]) begin
					t = 17'(s) + 17'(SettleStep);
					s = t[16] ? 16'hFFFF : t[15:0];
				end
				flags_q <= f;
				appr_q <= a;
				ent_q <= e;
				settle_q <= s;
			end
		end
	end

	// Level capture from the divider quotient, clamped.
	always_ff @(posedge clk) begin
		if (cmd.lvl_store) begin
			if (dzero_q) lvl_q[cmd.idx] <= '0;
			else if (dnum_q[14:0] > 15'(LevelMax)) lvl_q[cmd.idx] <= LevelMax;
			else lvl_q[cmd.idx] <= dnum_q[6:0];
		end
	end

	// Square roots: idx 0 gives lq, 1 gives rq, 2 gives ri.
	assign sq_remsh = {sq_rem_q, sq_v_q[35:34]};
	assign sq_trial = {18'd0, sq_res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (cmd.sq_load) begin
			case (cmd.idx)
				2'd0: sq_v_q <= {3'd0, ls_sum, 16'd0};
				2'd1: sq_v_q <= {3'd0, rs_sum, 16'd0};
				default: sq_v_q <= {19'd0, rs_sum};
			endcase
			sq_rem_q <= '0;
			sq_res_q <= '0;
			sq_cnt_q <= 5'd18;
		end else if (cmd.sq_step && sq_cnt_q != 5'd0) begin
			sq_cnt_q <= sq_cnt_q - 5'd1;
			sq_v_q <= {sq_v_q[33:0], 2'b00};
			if (sq_remsh >= sq_trial) begin
				sq_rem_q <= 36'(sq_remsh - sq_trial);
				sq_res_q <= {sq_res_q[16:0], 1'b1};
			end else begin
				sq_rem_q <= sq_remsh[35:0];
				sq_res_q <= {sq_res_q[16:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_store) begin
			case (cmd.idx)
				2'd0: lq_q <= sq_res_q;
				2'd1: rq_q <= sq_res_q;
				default: ri_q <= sq_res_q[9:0];
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (stat.fixed_err) steer_error <= $signed(ExitError);
			else if (dneg_q) steer_error <= 14'(-$signed({1'b0, dnum_q[13:0]}));
			else steer_error <= $signed(dnum_q[13:0]);
			left_level <= lvl_q[0];
			left_slant_level <= lvl_q[1];
			right_slant_level <= lvl_q[2];
			right_level <= lvl_q[3];
			ring_seen <= flags_q[0];
			ring_entering <= flags_q[1];
			ring_inside <= flags_q[2];
			ring_leaving <= flags_q[3];
		end
	end

endmodule

// ===== rtl/isr_ctrl.sv =====
module isr_ctrl
	import isr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  isr_stat_t stat,
	output isr_cmd_t  cmd
);

	isr_state_t state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       ovalid_q, ovalid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			ovalid_q <= ovalid_d;
		end
	end

	assign out_valid = ovalid_q;
	assign in_ready = (state_q == ST_IDLE);

	// Sequencing of levels, mode update, roots and the error division.
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		ovalid_d = ovalid_q && !out_ready;
		cmd = '0;
		cmd.idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d = ST_LVL_LOAD;
				end
			end
			ST_LVL_LOAD: begin
				cmd.lvl_load = 1'b1;
				state_d = ST_LVL_DIV;
			end
			ST_LVL_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = ST_LVL_STORE;
			end
			ST_LVL_STORE: begin
				cmd.lvl_store = 1'b1;
				idx_d = idx_q + 2'd1;
				state_d = (idx_q == 2'd3) ? ST_MODE : ST_LVL_LOAD;
			end
			ST_MODE: begin
				cmd.mode_update = 1'b1;
				state_d = ST_SQ_LOAD;
			end
			ST_SQ_LOAD: begin
				cmd.sq_load = 1'b1;
				state_d = ST_SQ_RUN;
			end
			ST_SQ_RUN: begin
				cmd.sq_step = 1'b1;
				if (stat.sq_done) state_d = ST_SQ_STORE;
			end
			ST_SQ_STORE: begin
				cmd.sq_store = 1'b1;
				idx_d = idx_q + 2'd1;
				state_d = (idx_q == 2'd2) ? ST_ERR_LOAD : ST_SQ_LOAD;
			end
			ST_ERR_LOAD: begin
				cmd.err_load = 1'b1;
				state_d = ST_ERR_DIV;
			end
			ST_ERR_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				// Wait for the previous result to drain before overwriting it.
				if (!ovalid_q || out_ready) begin
					cmd.out_load = 1'b1;
					ovalid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/inductor_steering_error_ring_fsm.sv =====
// Inductor steering error with roundabout tracking. One request is taken at a
// time and captured at acceptance. The time until its result appears is set
// by the single shared bit-serial divider (four level divisions and one error
// division) and the bit-serial square root unit (three roots), plus load and
// store states around each level division and root, an error load state, and
// a state each for the mode update and the output load. The result sits in
// an output register, so the next request can be accepted while it waits.
// Configuration writes are taken at any cycle and must only be made while the
// block is idle.
module inductor_steering_error_ring_fsm
	import isr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         left_raw,
	input  logic [7:0]         left_slant_raw,
	input  logic [7:0]         right_slant_raw,
	input  logic [7:0]         right_raw,
	input  logic signed [15:0] wheel_speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [13:0] steer_error,
	output logic [6:0]         left_level,
	output logic [6:0]         left_slant_level,
	output logic [6:0]         right_slant_level,
	output logic [6:0]         right_level,
	output logic               ring_seen,
	output logic               ring_entering,
	output logic               ring_inside,
	output logic               ring_leaving,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0] max_word_q, min_word_q;
	logic [7:0]  enter_sum_q;
	logic [15:0] entry_dist_q, ring_dist_q, settle_lim_q;
	logic [8:0]  exit_sum_q;
	isr_cmd_t    cmd;
	isr_stat_t   stat;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_word_q <= MaxWordReset;
			min_word_q <= MinWordReset;
			enter_sum_q <= EnterSumReset;
			entry_dist_q <= EntryDistReset;
			ring_dist_q <= RingDistReset;
			exit_sum_q <= ExitSumReset;
			settle_lim_q <= SettleReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegMaxWord: max_word_q <= cfg_data;
				RegMinWord: min_word_q <= cfg_data;
				RegEnterSum: enter_sum_q <= cfg_data[7:0];
				RegEntryDist: entry_dist_q <= cfg_data[15:0];
				RegRingDist: ring_dist_q <= cfg_data[15:0];
				RegExitSum: exit_sum_q <= cfg_data[8:0];
				RegSettle: settle_lim_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	isr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	isr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.left_raw(left_raw), .left_slant_raw(left_slant_raw),
		.right_slant_raw(right_slant_raw), .right_raw(right_raw),
		.wheel_speed(wheel_speed),
		.max_word(max_word_q), .min_word(min_word_q),
		.enter_sum(enter_sum_q), .entry_dist(entry_dist_q),
		.ring_dist(ring_dist_q), .exit_sum(exit_sum_q), .settle_lim(settle_lim_q),
		.steer_error(steer_error),
		.left_level(left_level), .left_slant_level(left_slant_level),
		.right_slant_level(right_slant_level), .right_level(right_level),
		.ring_seen(ring_seen), .ring_entering(ring_entering),
		.ring_inside(ring_inside), .ring_leaving(ring_leaving)
	);

endmodule

// ===== tb/inductor_steering_error_ring_fsm_tb.sv =====
module inductor_steering_error_ring_fsm_tb
	import isr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 5000;
	localparam int HoldCycles = 600;
	localparam logic [2:0] RegUnused = 3'd7;

	typedef struct {
		logic [7:0]         l;
		logic [7:0]         ls;
		logic [7:0]         rs;
		logic [7:0]         r;
		logic signed [15:0] spd;
	} tick_t;

	typedef struct {
		logic signed [13:0] err;
		logic [6:0]         l;
		logic [6:0]         ls;
		logic [6:0]         rs;
		logic [6:0]         r;
		logic [3:0]         flags;
	} steer_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         left_raw = '0;
	logic [7:0]         left_slant_raw = '0;
	logic [7:0]         right_slant_raw = '0;
	logic [7:0]         right_raw = '0;
	logic signed [15:0] wheel_speed = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [13:0] steer_error;
	logic [6:0]         left_level;
	logic [6:0]         left_slant_level;
	logic [6:0]         right_slant_level;
	logic [6:0]         right_level;
	logic               ring_seen;
	logic               ring_entering;
	logic               ring_inside;
	logic               ring_leaving;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	inductor_steering_error_ring_fsm dut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the configuration and the ring tracking state.
	logic [31:0] max_word;
	logic [31:0] min_word;
	logic [7:0]  enter_sum;
	logic [15:0] entry_dist;
	logic [15:0] ring_dist;
	logic [8:0]  exit_sum;
	logic [15:0] settle_lim;
	logic [3:0]  ring_flags;
	logic [15:0] approach_dist;
	logic [15:0] enter_dist;
	logic [15:0] settle_cnt;

	steer_result_t expected_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Error from the left and right root-sum-square magnitudes, Q8.
	function automatic longint pair_steer(longint a, longint b, longint c, longint d);
		longint lq;
		longint rq;
		longint ri;
		lq = longint'(int_sqrt((a * a + b * b) << 16));
		rq = longint'(int_sqrt((c * c + d * d) << 16));
		ri = longint'(int_sqrt(c * c + d * d));
		return ((ri * 256 - lq) * 5120) / (lq + rq + 256);
	endfunction

	function automatic logic [6:0] scale_level(logic [7:0] raw, logic [7:0] mx, logic [7:0] mn);
		int v;
		v = 0;
		if (mx > mn) begin
			v = ((int'(raw) - int'(mn)) * 100) / (int'(mx) - int'(mn));
			if (v < 0) v = 0;
			if (v > int'(LevelMax)) v = int'(LevelMax);
		end
		return v[6:0];
	endfunction

	function automatic logic [15:0] sat_add(logic [15:0] a, int b);
		int s;
		s = int'(a) + b;
		return (s > 65535) ? 16'hFFFF : s[15:0];
	endfunction

	// Advances the shadow ring state by one tick and returns the expected outputs.
	task automatic predict_tick(input tick_t t, output steer_result_t e);
		int L;
		int LS;
		int RS;
		int R;
		int mag;
		longint err;
		e.l = scale_level(t.l, max_word[7:0], min_word[7:0]);
		e.ls = scale_level(t.ls, max_word[15:8], min_word[15:8]);
		e.rs = scale_level(t.rs, max_word[23:16], min_word[23:16]);
		e.r = scale_level(t.r, max_word[31:24], min_word[31:24]);
		L = int'(e.l);
		LS = int'(e.ls);
		RS = int'(e.rs);
		R = int'(e.r);
		mag = (t.spd < 0) ? -int'(t.spd) : int'(t.spd);

		// Flag updates in priority order.
		if (L + R > int'(enter_sum)) ring_flags[0] = 1'b1;
		if (approach_dist > entry_dist && ring_flags[0] && RS > int'(SlantEnterMin))
			ring_flags[1] = 1'b1;
		if (ring_flags[1] && enter_dist > ring_dist) ring_flags[2] = 1'b1;
		if (ring_flags[2] && L + R + RS + LS > int'(exit_sum)) begin
			ring_flags[3] = 1'b1;
			approach_dist = '0;
			enter_dist = '0;
		end
		if (settle_cnt > settle_lim) begin
			ring_flags = '0;
			settle_cnt = '0;
		end

		// Distance and settle counters.
		if (ring_flags[0] && !ring_flags[1]) approach_dist = sat_add(approach_dist, mag);
		if (ring_flags[1] && !ring_flags[2]) enter_dist = sat_add(enter_dist, mag);
		if (ring_flags[3]) settle_cnt = sat_add(settle_cnt, int'(SettleStep));

		// Steering error pairing depends on the ring mode.
		if (ring_flags[0]) begin
			err = pair_steer(2 * L, LS, 2 * R, RS);
			if (ring_flags[1] && !ring_flags[2] && !ring_flags[3])
				err = pair_steer(L, LS, R, RS);
			if (ring_flags[2]) err = pair_steer(L, 2 * LS, R, 2 * RS);
			if (ring_flags[3] && ring_flags[2]) err = longint'(ExitError);
		end else begin
			err = pair_steer(L, 2 * LS, R, 2 * RS);
		end
		e.err = err[13:0];
		e.flags = ring_flags;
	endtask

	// Sends one request; the caller is at a rising edge. Valid stays high afterwards unless a random idle gap is inserted.
	task automatic send_tick(input tick_t t);
		steer_result_t e;
		in_valid <= 1'b1;
		left_raw <= t.l;
		left_slant_raw <= t.ls;
		right_slant_raw <= t.rs;
		right_raw <= t.r;
		wheel_speed <= t.spd;
		do @(posedge clk); while (!in_ready);
		predict_tick(t, e);
		expected_q.push_back(e);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register while the block is idle.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			RegMaxWord:   max_word = data;
			RegMinWord:   min_word = data;
			RegEnterSum:  enter_sum = data[7:0];
			RegEntryDist: entry_dist = data[15:0];
			RegRingDist:  ring_dist = data[15:0];
			RegExitSum:   exit_sum = data[8:0];
			RegSettle:    settle_lim = data[15:0];
			default: ;
		endcase
	endtask

	function automatic tick_t make_tick(int l, int ls, int rs, int r, int spd);
		tick_t t;
		t.l = l[7:0];
		t.ls = ls[7:0];
		t.rs = rs[7:0];
		t.r = r[7:0];
		t.spd = spd[15:0];
		return t;
	endfunction

	// Mostly strong samples that carry the ring machine through its modes, some noise.
	function automatic tick_t random_tick();
		tick_t t;
		t.spd = 16'($urandom());
		if ($urandom_range(99) < 75) begin
			t.l = 8'($urandom_range(255, 110));
			t.ls = 8'($urandom_range(255, 60));
			t.rs = 8'($urandom_range(255, 60));
			t.r = 8'($urandom_range(255, 110));
			if ($urandom_range(3) == 0) t.spd = 16'($signed(16'($urandom_range(600))) - 300);
		end else begin
			t.l = 8'($urandom());
			t.ls = 8'($urandom());
			t.rs = 8'($urandom());
			t.r = 8'($urandom());
		end
		return t;
	endfunction

	task automatic test_directed();
		send_tick(make_tick(0, 0, 0, 0, 0));
		send_tick(make_tick(255, 255, 255, 255, 32767));
		send_tick(make_tick(255, 0, 255, 0, -32768));
		send_tick(make_tick(200, 200, 200, 200, -32768));
		send_tick(make_tick(200, 200, 200, 200, 1));
		send_tick(make_tick(250, 200, 175, 250, 0));
		send_tick(make_tick(1, 1, 1, 1, -1));
		send_tick(make_tick(0, 255, 0, 255, 100));
		send_tick(make_tick(255, 255, 0, 0, 0));
		send_tick(make_tick(0, 0, 255, 255, 0));
		// Settle limit of zero clears the flags on the next tick.
		write_reg(RegSettle, 32'd0);
		send_tick(make_tick(255, 255, 255, 255, 5));
		send_tick(make_tick(255, 255, 255, 255, 5));
		// Degenerate ranges and samples under the minimum.
		write_reg(RegMaxWord, 32'h0180_FF01);
		write_reg(RegMinWord, 32'h0280_0080);
		send_tick(make_tick(0, 0, 0, 0, 7));
		send_tick(make_tick(255, 255, 255, 255, -7));
		send_tick(make_tick(127, 128, 129, 3, 0));
		// Oversized values are masked, an unknown index is ignored.
		write_reg(RegEnterSum, 32'hFFFF_FF00);
		write_reg(RegExitSum, 32'hFFFF_FE00);
		write_reg(RegUnused, 32'hFFFF_FFFF);
		write_reg(RegMaxWord, MaxWordReset);
		write_reg(RegMinWord, MinWordReset);
		send_tick(make_tick(0, 0, 0, 0, 0));
		send_tick(make_tick(30, 30, 30, 30, 0));
	endtask

	// Cycles through register settings, extremes included, with random ticks.
	task automatic test_config_sweep();
		write_reg(RegMaxWord, 32'hFFFF_FFFF);
		write_reg(RegMinWord, 32'h0000_0000);
		write_reg(RegEnterSum, 32'd200);
		write_reg(RegEntryDist, 32'hFFFF_FFFF);
		write_reg(RegRingDist, 32'hFFFF_FFFF);
		write_reg(RegExitSum, 32'd400);
		write_reg(RegSettle, 32'hFFFF_FFFF);
		repeat (60) send_tick(random_tick());
		write_reg(RegEnterSum, 32'd0);
		write_reg(RegEntryDist, 32'd0);
		write_reg(RegRingDist, 32'd0);
		write_reg(RegExitSum, 32'd0);
		write_reg(RegSettle, 32'd0);
		repeat (60) send_tick(random_tick());
		write_reg(RegMaxWord, MaxWordReset);
		write_reg(RegMinWord, MinWordReset);
		write_reg(RegEnterSum, EnterSumReset);
		write_reg(RegEntryDist, EntryDistReset);
		write_reg(RegRingDist, RingDistReset);
		write_reg(RegExitSum, ExitSumReset);
		write_reg(RegSettle, SettleReset);
		repeat (60) send_tick(random_tick());
	endtask

	task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0) begin
				write_reg(RegMaxWord, $urandom_range(3) == 0 ? $urandom() : 32'hF0F0_F0F0);
				write_reg(RegMinWord, $urandom_range(3) == 0 ? $urandom() : 32'h1010_1010);
				write_reg(RegEnterSum, $urandom_range(200));
				write_reg(RegEntryDist, $urandom_range(60000));
				write_reg(RegRingDist, $urandom_range(60000));
				write_reg(RegExitSum, $urandom_range(400));
				write_reg(RegSettle, $urandom_range(400));
			end
			send_tick(random_tick());
		end
	endtask

	// The receiver stops for a long stretch while requests keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk) hold_len = HoldCycles;
		@(posedge clk);
		repeat (40) send_tick(random_tick());
	endtask

	// Receiver ready with random stalls and the long hold-off.
	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len = hold_len - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compares each result against the oldest expectation.
	always @(posedge clk) begin
		steer_result_t e;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t ERROR unexpected result err=%0d", $time, steer_error);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (e.err !== steer_error || e.l !== left_level || e.ls !== left_slant_level
						|| e.rs !== right_slant_level || e.r !== right_level
						|| e.flags !== {ring_leaving, ring_inside, ring_entering, ring_seen}) begin
					$display("%0t ERROR expected err=%0d lv=%0d/%0d/%0d/%0d flags=%b", $time,
						e.err, e.l, e.ls, e.rs, e.r, e.flags);
					$display("%0t ERROR actual   err=%0d lv=%0d/%0d/%0d/%0d flags=%b", $time,
						steer_error, left_level, left_slant_level, right_slant_level,
						right_level, {ring_leaving, ring_inside, ring_entering, ring_seen});
					errors++;
				end
			end
		end
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin
		int quiet;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| (!in_valid && !cfg_valid && expected_q.size() == 0))
			quiet = 0;
		else
			quiet++;
		if (quiet >= StallLimit) begin
			$display("%0t ERROR no progress, %0d results outstanding", $time, expected_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		max_word = MaxWordReset;
		min_word = MinWordReset;
		enter_sum = EnterSumReset;
		entry_dist = EntryDistReset;
		ring_dist = RingDistReset;
		exit_sum = ExitSumReset;
		settle_lim = SettleReset;
		ring_flags = '0;
		approach_dist = '0;
		enter_dist = '0;
		settle_cnt = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random(600, 24, 50);
		test_backpressure();
		test_random(600, 50, 24);
		test_random(500, 0, 0);
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/isr_pkg.sv
rtl/isr_datapath.sv
rtl/isr_ctrl.sv
rtl/inductor_steering_error_ring_fsm.sv
tb/inductor_steering_error_ring_fsm_tb.sv
